// ===== rtl/sfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor frame CRC decode package
// Shared widths, constants, the CRC-8 byte step and the inter-module structs.
// ----------------------------------------------------------------------------
package sfcd_pkg;

   localparam int BYTE_W  = 8;
   localparam int RAW_W   = 16;
   localparam int SPAN_W  = 15;
   localparam int PROD_W  = RAW_W + SPAN_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int QUOT_W  = 15;
   localparam int TEMP_W  = 15;
   localparam int HUM_W   = 14;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

   // full-scale spans in hundredths
   localparam logic [SPAN_W-1:0] TEMP_SPAN   = 15'd17500;
   localparam logic [SPAN_W-1:0] HUM_SPAN    = 15'd10000;
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;

   // per-lane result handed to the merge stage
   typedef struct packed {
      logic              match;
      logic [QUOT_W-1:0] quot;
   } lane_res_type;

   // pipeline advance strobes, one per stage
   typedef struct packed {
      logic adv_s1;
      logic adv_s2;
      logic adv_s3;
   } stage_ctl_type;

   // One byte of CRC-8, MSB first, no reflection
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc_in ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/sfcd_if.sv =====
// ----------------------------------------------------------------------------
// Sensor frame CRC decode channel interfaces
// Valid/ready channels for the reply frame and for the decoded result.
// ----------------------------------------------------------------------------
interface sfcd_req_if import sfcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] temp_msb;
   logic [BYTE_W-1:0] temp_lsb;
   logic [BYTE_W-1:0] temp_check;
   logic [BYTE_W-1:0] hum_msb;
   logic [BYTE_W-1:0] hum_lsb;
   logic [BYTE_W-1:0] hum_check;
   logic              temp_only;

   modport source (output valid, temp_msb, temp_lsb, temp_check,
                   hum_msb, hum_lsb, hum_check, temp_only,
                   input ready);
   modport sink   (input valid, temp_msb, temp_lsb, temp_check,
                   hum_msb, hum_lsb, hum_check, temp_only,
                   output ready);
endinterface

interface sfcd_rsp_if import sfcd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     frame_ok;
   logic signed [TEMP_W-1:0] temp_centi;
   logic        [HUM_W-1:0]  hum_centi;

   modport source (output valid, frame_ok, temp_centi, hum_centi, input ready);
   modport sink   (input valid, frame_ok, temp_centi, hum_centi, output ready);
endinterface

// ===== rtl/sfcd_lane.sv =====
// ----------------------------------------------------------------------------
// Sensor frame CRC decode lane
// Checks one word against its CRC-8 byte and scales it by span/65535.
// Two stages: first CRC byte and multiply, then second CRC byte and divide.
// ----------------------------------------------------------------------------
module sfcd_lane import sfcd_pkg::*; (
   input  logic              clock,
   input  stage_ctl_type     ctl,
   input  logic [BYTE_W-1:0] msb,
   input  logic [BYTE_W-1:0] lsb,
   input  logic [BYTE_W-1:0] check,
   input  logic [SPAN_W-1:0] span,
   output lane_res_type      res
);

   logic [BYTE_W-1:0] crc1_ff, crc1_in;
   logic [BYTE_W-1:0] lsb_ff;
   logic [BYTE_W-1:0] check_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   lane_res_type      res_ff, res_in;
   logic [SUM_W-1:0]  sum;

   // Stage 1: high byte through the CRC, raw word times span
   always_comb begin
      crc1_in = crc8_byte(CRC_INIT, msb);
      prod_in = PROD_W'({msb, lsb}) * PROD_W'(span);
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_s1) begin
         crc1_ff  <= crc1_in;
         lsb_ff   <= lsb;
         check_ff <= check;
         prod_ff  <= prod_in;
      end
   end

   // Stage 2: low byte through the CRC; floor(p/65535) = (p + (p>>16) + 1) >> 16
   always_comb begin
      sum          = SUM_W'(prod_ff) + SUM_W'(prod_ff >> RAW_W) + SUM_W'(1);
      res_in.match = (crc8_byte(crc1_ff, lsb_ff) == check_ff);
      res_in.quot  = sum[RAW_W +: QUOT_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_s2) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/sfcd_merge.sv =====
// ----------------------------------------------------------------------------
// Sensor frame CRC decode merge stage
// Combines the lane checks into frame_ok and forms the output register.
// ----------------------------------------------------------------------------
module sfcd_merge import sfcd_pkg::*; (
   input  logic                     clock,
   input  stage_ctl_type            ctl,
   input  lane_res_type             temp_res,
   input  lane_res_type             hum_res,
   input  logic                     temp_only,
   output logic                     frame_ok,
   output logic signed [TEMP_W-1:0] temp_centi,
   output logic        [HUM_W-1:0]  hum_centi
);

   logic              ok_ff, ok_in;
   logic [TEMP_W-1:0] temp_ff, temp_in;
   logic [HUM_W-1:0]  hum_ff, hum_in;

   // Drop both values on a failed check; drop humidity in temperature-only mode
   always_comb begin
      ok_in   = temp_res.match && (temp_only || hum_res.match);
      temp_in = ok_in ? (TEMP_W'(temp_res.quot) - TEMP_OFFSET) : '0;
      hum_in  = (ok_in && !temp_only) ? hum_res.quot[HUM_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_s3) begin
         ok_ff   <= ok_in;
         temp_ff <= temp_in;
         hum_ff  <= hum_in;
      end
   end

   assign frame_ok   = ok_ff;
   assign temp_centi = signed'(temp_ff);
   assign hum_centi  = hum_ff;

endmodule

// ===== rtl/sensor_frame_crc_decode_unit.sv =====
// ----------------------------------------------------------------------------
// Sensor frame CRC decode unit
// Checks the two CRC-8 bytes of a six-byte sensor reply frame and decodes
// temperature and humidity in hundredths.
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    temp/hum bytes, check bytes, temp_only
//   rsp_ch    out        valid/ready    frame_ok, temp_centi, hum_centi
//
// One frame per cycle sustained while the result channel is not stalled; the
// pipeline holds two lane stages and one merge/output stage. The temperature
// and humidity lanes run side by side; the lane multiplier and the
// divide-by-65535 add set the stage depth. Reset (synchronous, active high)
// empties the pipeline. A stalled result holds in the output register; each
// stage advances whenever the next one is empty or moving, so bubbles close up.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decode_unit import sfcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sfcd_req_if.sink   req_ch,
   sfcd_rsp_if.source rsp_ch
);

   logic          v1_ff, v1_in;
   logic          v2_ff, v2_in;
   logic          v3_ff, v3_in;
   logic          only1_ff;
   logic          only2_ff;
   logic          rdy1, rdy2, rdy3;
   stage_ctl_type ctl;
   lane_res_type  temp_res;
   lane_res_type  hum_res;

   // Stage ready chain from the output back to the input
   always_comb begin
      rdy3       = !v3_ff || rsp_ch.ready;
      rdy2       = !v2_ff || rdy3;
      rdy1       = !v1_ff || rdy2;
      ctl.adv_s1 = req_ch.valid && rdy1;
      ctl.adv_s2 = v1_ff && rdy2;
      ctl.adv_s3 = v2_ff && rdy3;
      v1_in      = rdy1 ? req_ch.valid : v1_ff;
      v2_in      = rdy2 ? v1_ff : v2_ff;
      v3_in      = rdy3 ? v2_ff : v3_ff;
   end

   assign req_ch.ready = rdy1;

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Carry the mode flag alongside the lanes
   always_ff @(posedge clock) begin
      if (ctl.adv_s1) begin
         only1_ff <= req_ch.temp_only;
      end
      if (ctl.adv_s2) begin
         only2_ff <= only1_ff;
      end
   end

   sfcd_lane u_temp_lane (
      .clock (clock),
      .ctl   (ctl),
      .msb   (req_ch.temp_msb),
      .lsb   (req_ch.temp_lsb),
      .check (req_ch.temp_check),
      .span  (TEMP_SPAN),
      .res   (temp_res)
   );

   sfcd_lane u_hum_lane (
      .clock (clock),
      .ctl   (ctl),
      .msb   (req_ch.hum_msb),
      .lsb   (req_ch.hum_lsb),
      .check (req_ch.hum_check),
      .span  (HUM_SPAN),
      .res   (hum_res)
   );

   sfcd_merge u_merge (
      .clock      (clock),
      .ctl        (ctl),
      .temp_res   (temp_res),
      .hum_res    (hum_res),
      .temp_only  (only2_ff),
      .frame_ok   (rsp_ch.frame_ok),
      .temp_centi (rsp_ch.temp_centi),
      .hum_centi  (rsp_ch.hum_centi)
   );

   assign rsp_ch.valid = v3_ff;

   // A failed frame carries zero values
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.frame_ok |-> rsp_ch.temp_centi == 0 && rsp_ch.hum_centi == 0)
      else $error("failed frame with nonzero value");

   // Decoded values stay in range
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.temp_centi >= -15'sd4500 && rsp_ch.temp_centi <= 15'sd13000
                       && rsp_ch.hum_centi <= 14'd10000)
      else $error("decoded value out of range");

   // An accepted frame fills the first stage
   a_fill : assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v1_ff)
      else $error("accepted frame lost at stage 1");

   // A stalled result keeps the output stage full and its frame_ok unchanged
   a_hold : assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rsp_ch.ready |=> v3_ff && $stable(rsp_ch.frame_ok))
      else $error("stalled result dropped");

   // The pipeline never refuses a frame while it has an empty stage 1
   a_ready : assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_ch.ready)
      else $error("input stalled with empty stage 1");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor frame CRC decode testbench
// Drives six-byte reply frames into the decode unit under random sender and
// receiver idling and predicts each reading from its own CRC-8 and scaling
// math. Every reading that comes out is checked field by field, in order,
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_top;
   import sfcd_pkg::*;

   localparam int PIPE_LATENCY   = 3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RAW_FULL       = 65535;
   localparam int RANDOM_FRAMES  = 580;

   // one reply frame as it sits on the request channel
   typedef struct packed {
      logic [BYTE_W-1:0] temp_msb;
      logic [BYTE_W-1:0] temp_lsb;
      logic [BYTE_W-1:0] temp_check;
      logic [BYTE_W-1:0] hum_msb;
      logic [BYTE_W-1:0] hum_lsb;
      logic [BYTE_W-1:0] hum_check;
      logic              temp_only;
   } frame_type;

   // one decoded reading as it sits on the result channel
   typedef struct packed {
      logic                     frame_ok;
      logic signed [TEMP_W-1:0] temp_centi;
      logic        [HUM_W-1:0]  hum_centi;
   } reading_type;

   logic clock = 1'b0;
   logic reset;

   sfcd_req_if req_ch ();
   sfcd_rsp_if rsp_ch ();

   sensor_frame_crc_decode_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   reading_type pending_readings[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          error_count   = 0;
   int          frames_sent   = 0;
   int          frames_good   = 0;
   int          frames_temp_only = 0;
   int          idle_cycles   = 0;

   always #5 clock = ~clock;

   // CRC-8 over a 16-bit word, shifted in one bit at a time, MSB first
   function automatic logic [BYTE_W-1:0] word_crc8(input logic [RAW_W-1:0] word);
      logic [BYTE_W-1:0] crc;
      logic              fb;
      crc = CRC_INIT;
      for (int i = RAW_W - 1; i >= 0; i--) begin
         fb  = crc[BYTE_W-1] ^ word[i];
         crc = {crc[BYTE_W-2:0], 1'b0};
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   // expected reading for one frame
   function automatic reading_type predict_reading(input frame_type f);
      reading_type r;
      logic        ok;
      int          raw_t;
      int          raw_h;
      int          temp_val;
      int          hum_val;
      raw_t = int'({f.temp_msb, f.temp_lsb});
      raw_h = int'({f.hum_msb, f.hum_lsb});
      ok = (word_crc8({f.temp_msb, f.temp_lsb}) == f.temp_check);
      if (!f.temp_only) begin
         ok = ok && (word_crc8({f.hum_msb, f.hum_lsb}) == f.hum_check);
      end
      temp_val = 0;
      hum_val  = 0;
      if (ok) begin
         temp_val = (raw_t * 17500) / RAW_FULL - 4500;
         if (!f.temp_only) begin
            hum_val = (raw_h * 10000) / RAW_FULL;
         end
      end
      r.frame_ok   = ok;
      r.temp_centi = temp_val[TEMP_W-1:0];
      r.hum_centi  = hum_val[HUM_W-1:0];
      return r;
   endfunction

   // build a frame from two words; a nonzero flip corrupts that check byte
   function automatic frame_type make_frame(input logic [RAW_W-1:0] t_word,
                                            input logic [RAW_W-1:0] h_word,
                                            input logic [BYTE_W-1:0] t_flip,
                                            input logic [BYTE_W-1:0] h_flip,
                                            input logic only);
      frame_type f;
      f.temp_msb   = t_word[15:8];
      f.temp_lsb   = t_word[7:0];
      f.temp_check = word_crc8(t_word) ^ t_flip;
      f.hum_msb    = h_word[15:8];
      f.hum_lsb    = h_word[7:0];
      f.hum_check  = word_crc8(h_word) ^ h_flip;
      f.temp_only  = only;
      return f;
   endfunction

   // send one frame: optional idle gap, then hold valid until the transfer
   task automatic send_frame(input frame_type f);
      int          gap;
      reading_type r;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.temp_msb   <= f.temp_msb;
      req_ch.temp_lsb   <= f.temp_lsb;
      req_ch.temp_check <= f.temp_check;
      req_ch.hum_msb    <= f.hum_msb;
      req_ch.hum_lsb    <= f.hum_lsb;
      req_ch.hum_check  <= f.hum_check;
      req_ch.temp_only  <= f.temp_only;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      // transfer happens at the coming rising edge
      r = predict_reading(f);
      pending_readings.push_back(r);
      frames_sent++;
      if (r.frame_ok) frames_good++;
      if (f.temp_only) frames_temp_only++;
      @(posedge clock);
   endtask

   // hold the sender off until every predicted reading has come back
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   // full-scale and mid-scale raw words with good checks, both modes
   task automatic test_boundary_words();
      send_frame(make_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0));
      send_frame(make_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b0));
      send_frame(make_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00, 1'b0));
      send_frame(make_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00, 1'b0));
      send_frame(make_frame(16'h8000, 16'h7FFF, 8'h00, 8'h00, 1'b0));
      send_frame(make_frame(16'h0001, 16'hFFFE, 8'h00, 8'h00, 1'b0));
      send_frame(make_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b1));
      send_frame(make_frame(16'h0000, 16'h1234, 8'h00, 8'h00, 1'b1));
   endtask

   // corrupted check bytes, including ones masked by temperature-only mode
   task automatic test_check_failures();
      frame_type f;
      send_frame(make_frame(16'h6666, 16'h9999, 8'h01, 8'h00, 1'b0));
      send_frame(make_frame(16'h6666, 16'h9999, 8'h00, 8'h80, 1'b0));
      send_frame(make_frame(16'hA5A5, 16'h5A5A, 8'hFF, 8'hFF, 1'b0));
      send_frame(make_frame(16'hA5A5, 16'h5A5A, 8'h10, 8'h00, 1'b1));
      send_frame(make_frame(16'hC0DE, 16'hBEEF, 8'h00, 8'h5A, 1'b1));
      // raw all-zero and all-one frames, checks not matching the data
      f = '{temp_msb: 8'h00, temp_lsb: 8'h00, temp_check: 8'h00,
            hum_msb: 8'h00, hum_lsb: 8'h00, hum_check: 8'h00, temp_only: 1'b0};
      send_frame(f);
      f = '{temp_msb: 8'hFF, temp_lsb: 8'hFF, temp_check: 8'hFF,
            hum_msb: 8'hFF, hum_lsb: 8'hFF, hum_check: 8'hFF, temp_only: 1'b1};
      send_frame(f);
      f = '{temp_msb: 8'hFF, temp_lsb: 8'hFF, temp_check: 8'hFF,
            hum_msb: 8'hFF, hum_lsb: 8'hFF, hum_check: 8'hFF, temp_only: 1'b0};
      send_frame(f);
   endtask

   // mostly well-formed frames with random words, some corrupted, some noise
   task automatic send_random_frame();
      logic [RAW_W-1:0] t_word;
      logic [RAW_W-1:0] h_word;
      frame_type        f;
      int               kind;
      t_word = 16'($urandom_range(0, 65535));
      h_word = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 19) == 0) t_word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(0, 19) == 0) h_word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      kind = $urandom_range(0, 9);
      case (kind)
         7: begin
            f = make_frame(t_word, h_word, 8'($urandom_range(1, 255)), 8'h00,
                           1'($urandom_range(0, 1)));
         end
         8: begin
            f = make_frame(t_word, h_word, 8'h00, 8'($urandom_range(1, 255)),
                           1'($urandom_range(0, 1)));
         end
         9: begin
            f = frame_type'({$urandom, 17'($urandom)});
            f.temp_only = 1'($urandom_range(0, 1));
         end
         default: begin
            f = make_frame(t_word, h_word, 8'h00, 8'h00, 1'($urandom_range(0, 1)));
         end
      endcase
      send_frame(f);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (RANDOM_FRAMES) send_random_frame();
   endtask

   // a burst, a full pause until the pipeline is empty, then another burst
   task automatic test_drain_pause();
      repeat (10) send_random_frame();
      wait_for_drain();
      repeat (10) send_random_frame();
   endtask

   // receiver readiness, redrawn every cycle
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // check each reading against the oldest prediction
   always @(negedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading: frame_ok %0b temp_centi %0d hum_centi %0d",
                     $time, rsp_ch.frame_ok, rsp_ch.temp_centi, rsp_ch.hum_centi);
            error_count++;
         end else begin
            exp_r = pending_readings.pop_front();
            if (rsp_ch.frame_ok !== exp_r.frame_ok) begin
               $display("%0t: frame_ok expected %0b actual %0b",
                        $time, exp_r.frame_ok, rsp_ch.frame_ok);
               error_count++;
            end
            if (rsp_ch.temp_centi !== exp_r.temp_centi) begin
               $display("%0t: temp_centi expected %0d actual %0d",
                        $time, exp_r.temp_centi, rsp_ch.temp_centi);
               error_count++;
            end
            if (rsp_ch.hum_centi !== exp_r.hum_centi) begin
               $display("%0t: hum_centi expected %0d actual %0d",
                        $time, exp_r.hum_centi, rsp_ch.hum_centi);
               error_count++;
            end
         end
      end
   end

   // end the run when work is pending but nothing transfers for too long
   always @(negedge clock) begin
      if (reset || !(req_ch.valid || pending_readings.size() != 0)
          || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d readings outstanding",
                  $time, pending_readings.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.temp_msb   <= '0;
      req_ch.temp_lsb   <= '0;
      req_ch.temp_check <= '0;
      req_ch.hum_msb    <= '0;
      req_ch.hum_lsb    <= '0;
      req_ch.hum_check  <= '0;
      req_ch.temp_only  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 75;
      test_boundary_words();
      test_check_failures();
      test_random_traffic(11, 75);
      test_drain_pause();
      test_random_traffic(75, 11);
      test_random_traffic(0, 0);

      // flush the pipeline, then give stray readings a chance to show up
      wait_for_drain();
      repeat (PIPE_LATENCY * 4) @(posedge clock);

      $display("Covered %0d frames over three idle mixes and a full drain pause.", frames_sent);
      $display("%0d frames passed their checks, %0d failed, %0d in temperature-only mode.",
               frames_good, frames_sent - frames_good, frames_temp_only);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
